/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define MRT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define MRT_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/mrt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_pkg
// Types, widths and latencies of the midpoint ray triangulation block.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int ROT_W      = 21;
  localparam int ROW_W      = 3 * ROT_W;
  localparam int IN_W       = 32;
  localparam int QW         = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int QDEPTH_DEF = 4;

  // datapath widths
  localparam int RP_W    = 53;             // rotation entry times image coordinate
  localparam int V2_W    = 55;             // rotated second ray
  localparam int DOT_P_W = 2 * V2_W;
  localparam int SUM_W   = 112;            // a, b, c, d, e
  localparam int WIDE_W  = 2 * SUM_W;
  localparam int NUM_W   = 178;
  localparam int DEN_W   = 174;            // denominator is never negative
  localparam int PROD_W  = IN_W + NUM_W;
  localparam int MAG_W   = PROD_W - 1;

  localparam logic signed [IN_W-1:0] ONE_Q24 = 32'sd16777216;

  localparam logic [ROW_W-1:0] ROT_ROW0_RST = 63'd524288;
  localparam logic [ROW_W-1:0] ROT_ROW1_RST = 63'd1099511627776;
  localparam logic [ROW_W-1:0] ROT_ROW2_RST = 63'd2305843009213693952;

  localparam logic [QW:0] LIM_POS = {2'b00, {(QW-1){1'b1}}};
  localparam logic [QW:0] LIM_NEG = {2'b01, {(QW-1){1'b0}}};
  localparam logic signed [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_ROW0 = 3'd0,
    CFG_ROT_ROW1 = 3'd1,
    CFG_ROT_ROW2 = 3'd2,
    CFG_TRANS_X  = 3'd3,
    CFG_TRANS_Y  = 3'd4,
    CFG_TRANS_Z  = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic signed [IN_W-1:0] ray1_x;
    logic signed [IN_W-1:0] ray1_y;
    logic signed [IN_W-1:0] ray2_x;
    logic signed [IN_W-1:0] ray2_y;
  } pair_t;

  typedef struct packed {
    logic signed [QW-1:0] out_x;
    logic signed [QW-1:0] out_y;
    logic signed [QW-1:0] out_z;
    logic                 parallel_rays;
    logic                 saturated;
  } point_t;

  typedef struct packed {
    logic [ROW_W-1:0]       rot_row0;
    logic [ROW_W-1:0]       rot_row1;
    logic [ROW_W-1:0]       rot_row2;
    logic signed [IN_W-1:0] trans_x;
    logic signed [IN_W-1:0] trans_y;
    logic signed [IN_W-1:0] trans_z;
  } cfg_t;

  // latency of mrt_mul: sign strip, one 32x32 partial product per stage, sign restore
  function automatic int mul_lat(input int wa, input int wb);
    return 2 + ((wa + 31) / 32) * ((wb + 31) / 32);
  endfunction

  localparam int LAT_DOT  = mul_lat(V2_W, V2_W);
  localparam int LAT_WIDE = mul_lat(SUM_W, SUM_W);
  localparam int LAT_PROD = mul_lat(IN_W, NUM_W);

  function automatic logic signed [ROT_W-1:0] rot_entry(input logic [ROW_W-1:0] row,
                                                        input int col);
    return row[ROT_W*col +: ROT_W];
  endfunction

endpackage

/* rtl/core/mrt_delay.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_delay
// Stallable shift line that keeps side data in step with the datapath.
// ----------------------------------------------------------------------------
module mrt_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [D];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < D; i++) taps[i] <= '0;
    end else if (en) begin
      taps[0] <= d;
      for (int i = 1; i < D; i++) taps[i] <= taps[i-1];
    end
  end

  assign q = taps[D-1];

endmodule

/* rtl/core/mrt_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_mul
// Pipelined signed multiplier, one 32x32 partial product per stage.
// ----------------------------------------------------------------------------
module mrt_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NA = (WA + 31) / 32;
  localparam int NB = (WB + 31) / 32;
  localparam int NP = NA * NB;
  localparam int WP = 32 * (NA + NB);

  logic [WA-1:0]      abs_a;
  logic [WB-1:0]      abs_b;
  logic [32*NA-1:0]   ma  [NP];
  logic [32*NB-1:0]   mb  [NP];
  logic               sg  [NP+1];
  logic [WP-1:0]      acc [NP+1];
  logic [WP-1:0]      fin;

  assign abs_a = a[WA-1] ? ~a + 1'b1 : a;
  assign abs_b = b[WB-1] ? ~b + 1'b1 : b;

  always_ff @(posedge clk) begin
    if (en) begin
      ma[0]  <= (32*NA)'(abs_a);
      mb[0]  <= (32*NB)'(abs_b);
      sg[0]  <= a[WA-1] ^ b[WB-1];
      acc[0] <= '0;
    end
  end

  for (genvar k = 0; k < NP; k++) begin : g_pp
    localparam int I = k / NB;
    localparam int J = k % NB;
    logic [63:0] pp;
    assign pp = ma[k][32*I +: 32] * mb[k][32*J +: 32];
    always_ff @(posedge clk) begin
      if (en) begin
        sg[k+1]  <= sg[k];
        acc[k+1] <= acc[k] + (WP'(pp) << (32 * (I + J)));
      end
    end
    if (k < NP - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          ma[k+1] <= ma[k];
          mb[k+1] <= mb[k];
        end
      end
    end
  end

  assign fin = sg[NP] ? ~acc[NP] + 1'b1 : acc[NP];

  always_ff @(posedge clk) begin
    if (en) begin
      p <= fin[WA+WB-1:0];
    end
  end

endmodule

/* rtl/core/mrt_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_div
// Three-lane restoring divider sharing one denominator, with round and clip.
// ----------------------------------------------------------------------------
module mrt_div
  import mrt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [DEN_W-1:0]       den,
  input  logic                   par,
  input  logic [2:0][PROD_W-1:0] num,
  output logic                   res_valid,
  output point_t                 res
);

  localparam int RW = DEN_W + 1;

  // sign strip
  logic [2:0][MAG_W-1:0] mag;
  logic [2:0]            sgn_a;
  logic [DEN_W-1:0]      den_a;
  logic                  par_a, vl_a;

  always_ff @(posedge clk) begin
    if (rst) vl_a <= 1'b0;
    else if (en) vl_a <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        sgn_a[l] <= num[l][PROD_W-1];
        mag[l]   <= MAG_W'(num[l][PROD_W-1] ? ~num[l] + 1'b1 : num[l]);
      end
      den_a <= den;
      par_a <= par;
    end
  end

  // quotient stages, one bit each, MSB first
  logic [2:0][RW-1:0] rem [QW+1];
  logic [2:0][QW-1:0] quo [QW+1];
  logic [2:0][QW-1:0] low [QW];
  logic [2:0]         sgn [QW+1];
  logic [2:0]         ovf [QW+1];
  logic [DEN_W-1:0]   dn  [QW+1];
  logic               pr  [QW+1];
  logic               vl  [QW+1];

  always_ff @(posedge clk) begin
    if (rst) vl[0] <= 1'b0;
    else if (en) vl[0] <= vl_a;
  end

  // a quotient of 2^48 or more is caught here and clipped at the end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rem[0][l] <= RW'(mag[l][MAG_W-1:QW]);
        ovf[0][l] <= RW'(mag[l][MAG_W-1:QW]) >= RW'(den_a);
        low[0][l] <= mag[l][QW-1:0];
        quo[0][l] <= '0;
      end
      sgn[0] <= sgn_a;
      dn[0]  <= den_a;
      pr[0]  <= par_a;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [2:0][RW-1:0] tr;
    logic [2:0]         ge;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        tr[l] = {rem[s][l][RW-2:0], low[s][l][QW-1-s]};
        ge[l] = tr[l] >= RW'(dn[s]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vl[s+1] <= 1'b0;
      else if (en) vl[s+1] <= vl[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          rem[s+1][l] <= ge[l] ? tr[l] - RW'(dn[s]) : tr[l];
          quo[s+1][l] <= {quo[s][l][QW-2:0], ge[l]};
        end
        sgn[s+1] <= sgn[s];
        ovf[s+1] <= ovf[s];
        dn[s+1]  <= dn[s];
        pr[s+1]  <= pr[s];
      end
    end

    if (s < QW - 1) begin : g_low
      always_ff @(posedge clk) begin
        if (en) low[s+1] <= low[s];
      end
    end
  end

  // round half away from zero, clip, restore sign
  logic [2:0][QW:0]   qr, mg, lim;
  logic [2:0]         st;
  logic [2:0][QW-1:0] val;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qr[l]  = {1'b0, quo[QW][l]}
             + (QW+1)'({rem[QW][l][RW-2:0], 1'b0} >= RW'(dn[QW]));
      lim[l] = sgn[QW][l] ? LIM_NEG : LIM_POS;
      st[l]  = ovf[QW][l] || (qr[l] > lim[l]);
      mg[l]  = st[l] ? lim[l] : qr[l];
      val[l] = sgn[QW][l] ? QW'(~mg[l] + 1'b1) : QW'(mg[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (en) res_valid <= vl[QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.out_x         <= pr[QW] ? '0 : val[0];
      res.out_y         <= pr[QW] ? '0 : val[1];
      res.out_z         <= pr[QW] ? '0 : val[2];
      res.parallel_rays <= pr[QW];
      res.saturated     <= !pr[QW] && (|st);
    end
  end

endmodule

/* rtl/core/mrt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_front
// Input side: takes point pairs and holds them in a short queue.
// ----------------------------------------------------------------------------
module mrt_front
  import mrt_pkg::*;
#(
  parameter int DEPTH = QDEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  pair_valid,
  output logic  pair_ready,
  input  pair_t pair,
  input  logic  pop,
  output logic  head_valid,
  output pair_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pair_t         slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          push;

  assign pair_ready = count != CW'(DEPTH);
  assign push       = pair_valid && pair_ready;
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= pair;
  end

endmodule

/* rtl/core/mrt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_back
// Triangulation datapath: rotate, dot products, numerator and denominator,
// scaled coordinates, division, output register.
// ----------------------------------------------------------------------------
module mrt_back
  import mrt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   head_valid,
  input  pair_t  head,
  output logic   pop,
  output logic   point_valid,
  input  logic   point_ready,
  output point_t point
);

  logic en;
  assign en  = !point_valid || point_ready;
  assign pop = en && head_valid;

  // rotate the second ray
  logic [ROW_W-1:0]        rows [3];
  logic                    va, vb;
  logic signed [IN_W-1:0]  x1a, y1a, x1b, y1b;
  logic signed [RP_W-1:0]  rp [3][3];
  logic signed [V2_W-1:0]  v2 [3];

  assign rows[0] = cfg.rot_row0;
  assign rows[1] = cfg.rot_row1;
  assign rows[2] = cfg.rot_row2;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= head_valid;
      vb <= va;
    end
  end

  // third component of each ray is 1.0 in Q8.24
  always_ff @(posedge clk) begin
    if (en) begin
      x1a <= head.ray1_x;
      y1a <= head.ray1_y;
      for (int i = 0; i < 3; i++) begin
        rp[i][0] <= rot_entry(rows[i], 0) * head.ray2_x;
        rp[i][1] <= rot_entry(rows[i], 1) * head.ray2_y;
        rp[i][2] <= RP_W'(rot_entry(rows[i], 2)) <<< 24;
      end
      x1b <= x1a;
      y1b <= y1a;
      for (int i = 0; i < 3; i++) begin
        v2[i] <= V2_W'(rp[i][0]) + V2_W'(rp[i][1]) + V2_W'(rp[i][2]);
      end
    end
  end

  // dot products a=v1.v1 b=v1.v2 c=v2.v2 d=t.v1 e=t.v2
  logic signed [V2_W-1:0]    v1e [3], te [3];
  logic signed [V2_W-1:0]    opa [15], opb [15];
  logic signed [DOT_P_W-1:0] dprd [15];
  logic signed [SUM_W-1:0]   dsum [5];

  assign v1e[0] = V2_W'(x1b);
  assign v1e[1] = V2_W'(y1b);
  assign v1e[2] = V2_W'(ONE_Q24);
  assign te[0]  = V2_W'(cfg.trans_x);
  assign te[1]  = V2_W'(cfg.trans_y);
  assign te[2]  = V2_W'(cfg.trans_z);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opa[i]    = v1e[i]; opb[i]    = v1e[i];
      opa[3+i]  = v1e[i]; opb[3+i]  = v2[i];
      opa[6+i]  = v2[i];  opb[6+i]  = v2[i];
      opa[9+i]  = te[i];  opb[9+i]  = v1e[i];
      opa[12+i] = te[i];  opb[12+i] = v2[i];
    end
  end

  for (genvar n = 0; n < 15; n++) begin : g_dot
    mrt_mul #(.WA(V2_W), .WB(V2_W)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (opa[n]),
      .b   (opb[n]),
      .p   (dprd[n])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 5; m++) begin
        dsum[m] <= SUM_W'(dprd[3*m]) + SUM_W'(dprd[3*m+1]) + SUM_W'(dprd[3*m+2]);
      end
    end
  end

  logic vc;
  mrt_delay #(.W(1), .D(LAT_DOT + 1)) u_vc (
    .clk (clk), .rst (rst), .en (en), .d (vb), .q (vc)
  );

  // numerator c*d - b*e, denominator a*c - b*b
  logic signed [WIDE_W-1:0] p_cd, p_be, p_ac, p_bb;

  mrt_mul #(.WA(SUM_W), .WB(SUM_W)) u_cd (
    .clk (clk), .en (en), .a (dsum[2]), .b (dsum[3]), .p (p_cd)
  );
  mrt_mul #(.WA(SUM_W), .WB(SUM_W)) u_be (
    .clk (clk), .en (en), .a (dsum[1]), .b (dsum[4]), .p (p_be)
  );
  mrt_mul #(.WA(SUM_W), .WB(SUM_W)) u_ac (
    .clk (clk), .en (en), .a (dsum[0]), .b (dsum[2]), .p (p_ac)
  );
  mrt_mul #(.WA(SUM_W), .WB(SUM_W)) u_bb (
    .clk (clk), .en (en), .a (dsum[1]), .b (dsum[1]), .p (p_bb)
  );

  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]        den;
  logic                    dzero;

  always_ff @(posedge clk) begin
    if (en) begin
      num   <= NUM_W'(p_cd - p_be);
      den   <= DEN_W'(p_ac - p_bb);
      dzero <= p_ac == p_bb;
    end
  end

  logic vd;
  mrt_delay #(.W(1), .D(LAT_WIDE + 1)) u_vd (
    .clk (clk), .rst (rst), .en (en), .d (vc), .q (vd)
  );

  logic [2*IN_W-1:0] v1_q;
  mrt_delay #(.W(2*IN_W), .D(LAT_DOT + LAT_WIDE + 2)) u_v1 (
    .clk (clk), .rst (rst), .en (en), .d ({x1b, y1b}), .q (v1_q)
  );

  // coordinate numerators x1*num, y1*num, 1.0*num
  logic signed [IN_W-1:0]  sc [3];
  logic [2:0][PROD_W-1:0]  prod;

  assign sc[0] = $signed(v1_q[2*IN_W-1:IN_W]);
  assign sc[1] = $signed(v1_q[IN_W-1:0]);
  assign sc[2] = ONE_Q24;

  for (genvar l = 0; l < 3; l++) begin : g_prod
    mrt_mul #(.WA(IN_W), .WB(NUM_W)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (sc[l]),
      .b   (num),
      .p   (prod[l])
    );
  end

  logic             ve, ze;
  logic [DEN_W-1:0] de;
  mrt_delay #(.W(DEN_W + 2), .D(LAT_PROD)) u_den (
    .clk (clk), .rst (rst), .en (en), .d ({vd, dzero, den}), .q ({ve, ze, de})
  );

  logic   rv;
  point_t res;

  mrt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ve),
    .den       (de),
    .par       (ze),
    .num       (prod),
    .res_valid (rv),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) point_valid <= 1'b0;
    else if (en) point_valid <= rv;
  end

  always_ff @(posedge clk) begin
    if (en) point <= res;
  end

endmodule

/* rtl/core/midpoint_ray_triangulation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ray_triangulation
// Midpoint triangulation of one matched point pair per item, exact
// fixed-point arithmetic with a single round-to-nearest per coordinate.
// ----------------------------------------------------------------------------
// Takes one item per clock while the queue has room. An accepted pair waits
// in a small input queue and then runs down a fixed pipeline: rotation, five
// dot products, the numerator and denominator products, the three scaled
// coordinates and a three-lane bit-per-stage divider. The divider's 48
// quotient stages and the multipliers, cut into 32x32 partial products, set
// the latency from accept to result. The whole pipeline holds while a
// finished point waits on point_ready; the queue keeps taking pairs until it
// is full. Parallel rays give zero coordinates with parallel_rays set.
// Configuration writes are taken at any time (cfg_ready is always high)
// and are meant for when the block is empty.
// ----------------------------------------------------------------------------
module midpoint_ray_triangulation
  import mrt_pkg::*;
#(
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pair_valid,
  output logic                  pair_ready,
  input  pair_t                 pair,
  output logic                  point_valid,
  input  logic                  point_ready,
  output point_t                point,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  logic  head_valid, pop;
  pair_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot_row0 <= ROT_ROW0_RST;
      cfg.rot_row1 <= ROT_ROW1_RST;
      cfg.rot_row2 <= ROT_ROW2_RST;
      cfg.trans_x  <= '0;
      cfg.trans_y  <= '0;
      cfg.trans_z  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROT_ROW0: cfg.rot_row0 <= cfg_data[ROW_W-1:0];
        CFG_ROT_ROW1: cfg.rot_row1 <= cfg_data[ROW_W-1:0];
        CFG_ROT_ROW2: cfg.rot_row2 <= cfg_data[ROW_W-1:0];
        CFG_TRANS_X:  cfg.trans_x  <= cfg_data[IN_W-1:0];
        CFG_TRANS_Y:  cfg.trans_y  <= cfg_data[IN_W-1:0];
        CFG_TRANS_Z:  cfg.trans_z  <= cfg_data[IN_W-1:0];
        default:      cfg <= cfg;
      endcase
    end
  end

  mrt_front #(.DEPTH(QDEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .pair       (pair),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mrt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point       (point)
  );

endmodule

/* rtl/core/mrt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_checker
// Port-level checks on the triangulation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrt_checker
  import mrt_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   pair_ready,
  input logic   point_valid,
  input logic   point_ready,
  input point_t point
);

  logic pt_zero, pt_at_lim;

  assign pt_zero = point.out_x == '0 && point.out_y == '0 && point.out_z == '0 &&
                   !point.saturated;
  assign pt_at_lim = point.out_x == SAT_POS || point.out_x == SAT_NEG ||
                     point.out_y == SAT_POS || point.out_y == SAT_NEG ||
                     point.out_z == SAT_POS || point.out_z == SAT_NEG;

  // parallel rays carry no coordinates and no clip
  `MRT_CHECK(a_parallel_zero, point_valid && point.parallel_rays |-> pt_zero, "parallel item")

  // a clipped item has at least one coordinate at a range limit
  `MRT_CHECK(a_sat_limit, point_valid && point.saturated |-> pt_at_lim, "saturated item")

  // out of reset: nothing to deliver, queue open
  `MRT_CHECK_ALWAYS(a_reset_state, $past(rst) |-> !point_valid && pair_ready, "not empty")

  `MRT_CHECK(a_out_hold, point_valid && !point_ready |=> point_valid && $stable(point), "held")

endmodule

bind midpoint_ray_triangulation mrt_checker u_mrt_checker (.*);
